// File: sv/mhs_pkg.sv
// ----------------------------------------------------------------------------
// mhs_pkg: shared types and constants for the mood hold stabilizer
// Mood codes, register indexes, reset values and the item, state, config and
// result records passed between the top level and the update logic.
// ----------------------------------------------------------------------------
package mhs_pkg;

    localparam int TIME_W = 48;
    localparam int TAG_W  = 32;
    localparam int MOOD_W = 4;
    localparam int CFG_W  = 16;
    localparam int HOLD_W = 17;
    localparam int IDX_W  = 2;

    // Mood codes
    localparam logic [MOOD_W-1:0] MOOD_IDLE     = 4'd0;
    localparam logic [MOOD_W-1:0] MOOD_THINKING = 4'd1;
    localparam logic [MOOD_W-1:0] MOOD_WORKING  = 4'd2;
    localparam logic [MOOD_W-1:0] MOOD_DONE     = 4'd3;
    localparam logic [MOOD_W-1:0] MOOD_BLOCKED  = 4'd4;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_ACTIVITY_DWELL = 2'd0;
    localparam logic [IDX_W-1:0] REG_DONE_HOLD      = 2'd1;
    localparam logic [IDX_W-1:0] REG_BLOCKED_HOLD   = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] ACTIVITY_DWELL_RESET = 16'd450;
    localparam logic [CFG_W-1:0] DONE_HOLD_RESET      = 16'd2400;
    localparam logic [CFG_W-1:0] BLOCKED_HOLD_RESET   = 16'd6000;

    // No hold pending
    localparam logic signed [HOLD_W-1:0] HOLD_NONE = -17'sd1;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [TAG_W-1:0]  moment_tag;
        logic [MOOD_W-1:0] raw_mood;
    } item_t;

    typedef struct packed {
        logic                     seen_any;
        logic [TAG_W-1:0]         last_played_tag;
        logic [TIME_W-1:0]        oneshot_deadline;
        logic                     oneshot_active;
        logic [MOOD_W-1:0]        current_mood;
        logic [TIME_W-1:0]        shown_since;
        logic                     shown_valid;
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] min_dwell;
        logic [CFG_W-1:0] done_hold;
        logic [CFG_W-1:0] blocked_hold;
    } cfg_t;

    typedef struct packed {
        logic [MOOD_W-1:0]        shown_mood;
        logic signed [HOLD_W-1:0] hold_remaining_ms;
    } result_t;

    function automatic logic is_busy_mood(input logic [MOOD_W-1:0] mood);
        is_busy_mood = (mood == MOOD_THINKING) || (mood == MOOD_WORKING);
    endfunction

endpackage

// File: sv/mhs_update.sv
// ----------------------------------------------------------------------------
// mhs_update: next-state and result logic for one update
// Pure combinational step: takes the held item, current state and
// configuration, returns the next state and the result.
// ----------------------------------------------------------------------------
module mhs_update
    import mhs_pkg::*;
(
    input  item_t   item,
    input  state_t  state,
    input  cfg_t    cfg,
    output state_t  state_next,
    output result_t result
);

    logic                is_oneshot;
    logic                play;
    logic [CFG_W-1:0]    hold_sel;
    logic [TIME_W:0]     end_sum;
    logic                end_sat;
    logic [TIME_W-1:0]   end_time;
    logic [TIME_W-1:0]   left_play;
    logic [TIME_W-1:0]   left_old;
    logic [TIME_W-1:0]   left_raw;
    logic [CFG_W-1:0]    left;
    logic                keep_play;
    logic                keep_old;
    logic                keep;
    logic [TIME_W:0]     elapsed_diff;
    logic [TIME_W-1:0]   elapsed;
    logic                dwell_case;
    logic                dwell_wait;
    logic [CFG_W-1:0]    dwell_left;

    assign is_oneshot = (item.raw_mood == MOOD_DONE) || (item.raw_mood == MOOD_BLOCKED);
    assign play       = is_oneshot && state.seen_any
                        && (item.moment_tag != state.last_played_tag);

    // Deadline for a newly played moment, saturated at the top of the time range
    assign hold_sel  = (item.raw_mood == MOOD_DONE) ? cfg.done_hold : cfg.blocked_hold;
    assign end_sum   = {1'b0, item.time_ms} + {{(TIME_W+1-CFG_W){1'b0}}, hold_sel};
    assign end_sat   = end_sum[TIME_W];
    assign end_time  = end_sat ? {TIME_W{1'b1}} : end_sum[TIME_W-1:0];
    // Remaining time on a new deadline, without going through the adder
    assign left_play = end_sat ? ~item.time_ms
                               : {{(TIME_W-CFG_W){1'b0}}, hold_sel};
    assign keep_play = (left_play != '0);

    assign left_old  = state.oneshot_deadline - item.time_ms;
    assign keep_old  = (state.current_mood == item.raw_mood) && state.oneshot_active
                       && (item.time_ms < state.oneshot_deadline);

    assign keep      = is_oneshot && (play ? keep_play : keep_old);
    assign left_raw  = play ? left_play : left_old;
    assign left      = (left_raw[TIME_W-1:CFG_W] != '0) ? {CFG_W{1'b1}}
                                                        : left_raw[CFG_W-1:0];

    // Activity dwell: time running backwards counts as no time elapsed
    assign elapsed_diff = {1'b0, item.time_ms} - {1'b0, state.shown_since};
    assign elapsed      = elapsed_diff[TIME_W] ? '0 : elapsed_diff[TIME_W-1:0];
    assign dwell_case   = (item.raw_mood != state.current_mood) && state.shown_valid
                          && is_busy_mood(state.current_mood)
                          && (is_busy_mood(item.raw_mood) || (item.raw_mood == MOOD_IDLE));
    assign dwell_wait   = dwell_case && (elapsed[TIME_W-1:CFG_W] == '0)
                          && (cfg.min_dwell > elapsed[CFG_W-1:0]);
    assign dwell_left   = cfg.min_dwell - elapsed[CFG_W-1:0];

    always_comb
    begin
        state_next          = state;
        state_next.seen_any = 1'b1;
        result.hold_remaining_ms = HOLD_NONE;

        if (is_oneshot)
        begin
            // Unplayed or first-seen tags are recorded either way
            state_next.last_played_tag = item.moment_tag;
            if (play)
            begin
                state_next.oneshot_active   = 1'b1;
                state_next.oneshot_deadline = end_time;
                if (!(state_next.current_mood == item.raw_mood && state_next.shown_valid))
                begin
                    state_next.current_mood = item.raw_mood;
                    state_next.shown_since  = item.time_ms;
                    state_next.shown_valid  = 1'b1;
                end
            end
            if (keep)
            begin
                result.hold_remaining_ms = signed'({1'b0, left});
            end
            else
            begin
                state_next.oneshot_deadline = '0;
                state_next.oneshot_active   = 1'b0;
                if (!(state_next.current_mood == MOOD_IDLE && state_next.shown_valid))
                begin
                    state_next.current_mood = MOOD_IDLE;
                    state_next.shown_since  = item.time_ms;
                    state_next.shown_valid  = 1'b1;
                end
            end
        end
        else
        begin
            state_next.oneshot_deadline = '0;
            state_next.oneshot_active   = 1'b0;
            if (dwell_wait)
            begin
                result.hold_remaining_ms = signed'({1'b0, dwell_left});
            end
            else if (!(state.current_mood == item.raw_mood && state.shown_valid))
            begin
                state_next.current_mood = item.raw_mood;
                state_next.shown_since  = item.time_ms;
                state_next.shown_valid  = 1'b1;
            end
        end

        result.shown_mood = state_next.current_mood;
    end

endmodule

// File: sv/mood_hold_stabilizer.sv
// ----------------------------------------------------------------------------
// mood_hold_stabilizer: steadies the displayed mood of a face animation
// A taken update waits in the input register, its result in the result register.
// Throughput: one update per cycle unless the result stream stalls.
// Reset (rst_n low, asynchronous): state cleared, mood idle, registers back to
// 450 / 2400 / 6000 ms, both stream stages emptied. No clearing pass.
// ----------------------------------------------------------------------------
module mood_hold_stabilizer
    import mhs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    // Update stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [87:0]         s_axis_tdata,   // raw_mood[3:0], moment_tag[35:4],
                                                // time_ms[83:36], zero pad[87:84]

    // Result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata,   // hold_remaining_ms[16:0],
                                                // shown_mood[20:17], zero pad[23:21]

    // Configuration write port
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    // Input register: holds the taken update while the logic works on it
    logic    in_valid_reg;
    item_t   item_reg;

    // Result register: parts the two stream sides
    logic    out_valid_reg;
    result_t result_reg;

    state_t  state_reg;
    state_t  state_next;
    cfg_t    cfg_reg;
    result_t result_next;
    logic    advance;

    // The result register frees up when empty or drained this cycle; the input
    // register refills in the same cycle it hands over, so an update per cycle.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, result_reg.shown_mood, result_reg.hold_remaining_ms};

    // Stream handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers: capture on transaction, advance on hand-over
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.raw_mood   <= s_axis_tdata[3:0];
            item_reg.moment_tag <= s_axis_tdata[35:4];
            item_reg.time_ms    <= s_axis_tdata[83:36];
        end
        if (in_valid_reg && advance)
        begin
            result_reg <= result_next;
        end
    end

    // Mood state: commit only when the update leaves for the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.seen_any         <= 1'b0;
            state_reg.last_played_tag  <= '0;
            state_reg.oneshot_deadline <= '0;
            state_reg.oneshot_active   <= 1'b0;
            state_reg.current_mood     <= MOOD_IDLE;
            state_reg.shown_since      <= '0;
            state_reg.shown_valid      <= 1'b0;
        end
        else if (in_valid_reg && advance)
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers; unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_dwell    <= ACTIVITY_DWELL_RESET;
            cfg_reg.done_hold    <= DONE_HOLD_RESET;
            cfg_reg.blocked_hold <= BLOCKED_HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ACTIVITY_DWELL: cfg_reg.min_dwell    <= cfg_data;
                REG_DONE_HOLD:      cfg_reg.done_hold    <= cfg_data;
                REG_BLOCKED_HOLD:   cfg_reg.blocked_hold <= cfg_data;
                default:            ;
            endcase
        end
    end

    mhs_update u_update (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // A running one-shot always belongs to a shown done or blocked mood
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.oneshot_active |->
            (state_reg.current_mood == MOOD_DONE || state_reg.current_mood == MOOD_BLOCKED))
        else $error("one-shot active while mood is not done or blocked");

    // The deadline is cleared whenever no one-shot runs
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.oneshot_active |-> (state_reg.oneshot_deadline == '0))
        else $error("stale one-shot deadline");

    // Nothing has been shown yet means the mood is still idle
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.shown_valid |-> (state_reg.current_mood == MOOD_IDLE))
        else $error("mood changed without being marked shown");

    // Every processed update marks the first update as seen
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> state_reg.seen_any)
        else $error("seen flag not set after an update");

    // A processed update always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> out_valid_reg)
        else $error("update lost between input and result register");

endmodule
